// ===== src/lks_pkg.sv =====
package lks_pkg;

  localparam int TIME_W  = 32;
  localparam int RXC_W   = 32;
  localparam int HBC_W   = 32;
  localparam int UPD_W   = 10;
  localparam int HBP_W   = 16;
  localparam int WIN_W   = 16;
  localparam int RTY_W   = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [UPD_W-1:0] RST_UPDATE_PERIOD    = UPD_W'(10);
  localparam logic [HBP_W-1:0] RST_HEARTBEAT_PERIOD = HBP_W'(200);
  localparam logic [WIN_W-1:0] RST_ALIVE_WINDOW     = WIN_W'(600);
  localparam logic [RTY_W-1:0] RST_RETRY_INTERVAL   = RTY_W'(4);
  localparam logic [RTY_W-1:0] RST_MAX_RETRIES      = RTY_W'(8);

  typedef enum logic [1:0] {
    ACT_TICK       = 2'd0,
    ACT_STATE_SENT = 2'd1,
    ACT_EVENT_SENT = 2'd2,
    ACT_UNUSED     = 2'd3
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_UPDATE_PERIOD    = 3'd0,
    CFG_HEARTBEAT_PERIOD = 3'd1,
    CFG_ALIVE_WINDOW     = 3'd2,
    CFG_RETRY_INTERVAL   = 3'd3,
    CFG_MAX_RETRIES      = 3'd4
  } cfg_index_t;

  typedef struct packed {
    logic [UPD_W-1:0] update_period_ms;
    logic [HBP_W-1:0] heartbeat_period_ms;
    logic [WIN_W-1:0] alive_window_ms;
    logic [RTY_W-1:0] retry_interval_ticks;
    logic [RTY_W-1:0] max_event_retries;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        action;
    logic [TIME_W-1:0] now_ms;
    logic [RXC_W-1:0]  rx_frame_count;
    logic              event_pending;
    logic              resend_ok;
    logic              heartbeat_ok;
  } item_t;

  typedef struct packed {
    logic              seeded;
    logic [TIME_W-1:0] period_base;
    logic [TIME_W-1:0] heartbeat_base;
    logic [RXC_W-1:0]  last_rx_count;
    logic [TIME_W-1:0] last_rx_time;
    logic              ever_received;
    logic              alive_flag;
    logic [HBC_W-1:0]  heartbeat_count;
    logic [RTY_W-1:0]  retry_tick_count;
    logic [RTY_W-1:0]  retry_count;
    logic              data_sent_flag;
  } state_t;

  typedef struct packed {
    logic             alive;
    logic             resend_event;
    logic             abandon_event;
    logic             send_heartbeat;
    logic [HBC_W-1:0] heartbeats_sent;
  } result_t;

endpackage

// ===== src/lks_step.sv =====
module lks_step (
  input  lks_pkg::cfg_t    cfg,
  input  lks_pkg::state_t  st,
  input  lks_pkg::item_t   item,
  output lks_pkg::state_t  st_next,
  output lks_pkg::result_t res
);
  import lks_pkg::*;

  logic [TIME_W-1:0] d_period;
  logic [TIME_W-1:0] d_hb;
  logic [TIME_W-1:0] d_rx;
  logic              rx_changed;
  logic              ever_new;
  logic [RTY_W-1:0]  tick_inc;
  logic              ds_mid;
  logic              resend;
  logic              abandon;
  logic              hb;

  assign d_period   = item.now_ms - st.period_base;
  assign d_hb       = item.now_ms - st.heartbeat_base;
  assign d_rx       = item.now_ms - st.last_rx_time;
  assign rx_changed = (item.rx_frame_count != st.last_rx_count);
  assign ever_new   = st.ever_received | rx_changed;
  assign tick_inc   = st.retry_tick_count + RTY_W'(1);

  always_comb begin
    st_next = st;
    resend  = 1'b0;
    abandon = 1'b0;
    hb      = 1'b0;
    ds_mid  = st.data_sent_flag;
    case (action_t'(item.action))
      ACT_TICK: begin
        if (!st.seeded) begin
          st_next.seeded         = 1'b1;
          st_next.period_base    = item.now_ms;
          st_next.heartbeat_base = item.now_ms;
        end else if (d_period >= TIME_W'(cfg.update_period_ms)) begin
          st_next.period_base = item.now_ms;
          if (rx_changed) begin
            st_next.last_rx_count = item.rx_frame_count;
            st_next.last_rx_time  = item.now_ms;
          end
          st_next.ever_received = ever_new;
          // a fresh frame makes the gap zero
          st_next.alive_flag = ever_new &
                               (rx_changed | (d_rx <= TIME_W'(cfg.alive_window_ms)));
          if (item.event_pending) begin
            if (tick_inc >= cfg.retry_interval_ticks) begin
              st_next.retry_tick_count = '0;
              if (st.retry_count >= cfg.max_event_retries) begin
                abandon = 1'b1;
              end else begin
                st_next.retry_count = st.retry_count + RTY_W'(1);
                resend = 1'b1;
                if (item.resend_ok) begin
                  ds_mid = 1'b1;
                end
              end
            end else begin
              st_next.retry_tick_count = tick_inc;
            end
          end
          st_next.data_sent_flag = ds_mid;
          if (d_hb >= TIME_W'(cfg.heartbeat_period_ms)) begin
            st_next.heartbeat_base = item.now_ms;
            if (ds_mid) begin
              st_next.data_sent_flag = 1'b0;
            end else begin
              hb = 1'b1;
              if (item.heartbeat_ok) begin
                st_next.heartbeat_count = st.heartbeat_count + HBC_W'(1);
              end
            end
          end
        end
      end
      ACT_STATE_SENT: begin
        st_next.data_sent_flag = 1'b1;
      end
      ACT_EVENT_SENT: begin
        st_next.retry_tick_count = '0;
        st_next.retry_count      = '0;
        st_next.data_sent_flag   = 1'b1;
      end
      default: begin
        // unused code: drop the request without effect
        st_next = st;
      end
    endcase
  end

  always_comb begin
    res.alive           = st_next.alive_flag;
    res.resend_event    = resend;
    res.abandon_event   = abandon;
    res.send_heartbeat  = hb;
    res.heartbeats_sent = st_next.heartbeat_count;
  end

endmodule

// ===== src/link_keepalive_retry_supervisor.sv =====
// Channel  | Handshake              | Carries
// ---------+------------------------+--------------------------------------------
// input    | in_valid / in_stall    | action, now_ms, rx_frame_count, flags
// output   | out_valid / out_stall  | alive, resend/abandon/heartbeat, count
// config   | cfg_valid / cfg_ready  | cfg_index, cfg_data (ready always high)
//
// One request per cycle while the result is not stalled; each is held in the
// input register and then resolved by the step logic into the result register.
// State is updated as a request moves from the input to the result register.
// Synchronous reset restores the default periods and clears all state.
// A stalled result holds; one more request is taken into the input register.
module link_keepalive_retry_supervisor (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          action,
  input  logic [lks_pkg::TIME_W-1:0]          now_ms,
  input  logic [lks_pkg::RXC_W-1:0]           rx_frame_count,
  input  logic                                event_pending,
  input  logic                                resend_ok,
  input  logic                                heartbeat_ok,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                alive,
  output logic                                resend_event,
  output logic                                abandon_event,
  output logic                                send_heartbeat,
  output logic [lks_pkg::HBC_W-1:0]           heartbeats_sent,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lks_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lks_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import lks_pkg::*;

  cfg_t    cfg;
  state_t  st;
  state_t  st_next;
  item_t   stage;
  logic    stage_valid;
  result_t res;
  result_t res_r;
  logic    out_free;
  logic    advance;
  logic    in_take;

  assign cfg_ready = 1'b1;
  assign out_free  = ~out_valid | ~out_stall;
  assign advance   = stage_valid & out_free;
  assign in_stall  = stage_valid & ~out_free;
  assign in_take   = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.update_period_ms     <= RST_UPDATE_PERIOD;
      cfg.heartbeat_period_ms  <= RST_HEARTBEAT_PERIOD;
      cfg.alive_window_ms      <= RST_ALIVE_WINDOW;
      cfg.retry_interval_ticks <= RST_RETRY_INTERVAL;
      cfg.max_event_retries    <= RST_MAX_RETRIES;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index_t'(cfg_index))
        CFG_UPDATE_PERIOD:    cfg.update_period_ms     <= cfg_data[UPD_W-1:0];
        CFG_HEARTBEAT_PERIOD: cfg.heartbeat_period_ms  <= cfg_data[HBP_W-1:0];
        CFG_ALIVE_WINDOW:     cfg.alive_window_ms      <= cfg_data[WIN_W-1:0];
        CFG_RETRY_INTERVAL:   cfg.retry_interval_ticks <= cfg_data[RTY_W-1:0];
        CFG_MAX_RETRIES:      cfg.max_event_retries    <= cfg_data[RTY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_take) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      stage.action         <= action;
      stage.now_ms         <= now_ms;
      stage.rx_frame_count <= rx_frame_count;
      stage.event_pending  <= event_pending;
      stage.resend_ok      <= resend_ok;
      stage.heartbeat_ok   <= heartbeat_ok;
    end
  end

  lks_step u_step (
    .cfg     (cfg),
    .st      (st),
    .item    (stage),
    .st_next (st_next),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_free) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign alive           = res_r.alive;
  assign resend_event    = res_r.resend_event;
  assign abandon_event   = res_r.abandon_event;
  assign send_heartbeat  = res_r.send_heartbeat;
  assign heartbeats_sent = res_r.heartbeats_sent;

  a_one_retry_decision: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(resend_event && abandon_event))
    else $error("resend and abandon requested together");

  a_count_tracks_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (heartbeats_sent == st.heartbeat_count && alive == st.alive_flag))
    else $error("held result disagrees with supervisor state");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    advance |=> (st.heartbeat_count == $past(st.heartbeat_count) ||
                 st.heartbeat_count == $past(st.heartbeat_count) + HBC_W'(1)))
    else $error("heartbeat count moved by more than one");

  a_rx_after_seed: assert property (@(posedge clk) disable iff (rst)
    st.ever_received |-> st.seeded)
    else $error("receive history before time bases were seeded");

endmodule
